/* src/owbm_pkg.sv */
// Shared types, constants and register codes for the 1-Wire bus master.
// No dependencies; used by every module of the block.
package owbm_pkg;

  localparam int COUNT_WIDTH = 10;
  localparam int CMP_WIDTH   = ((COUNT_WIDTH > 10) ? COUNT_WIDTH : 10) + 1;

  localparam int CFG_WIDTH   = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SMPL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TOTAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SMPL     = 3'd5;

  // configuration reset values
  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [9:0] PRESENCE_SMPL_DEF = 10'd600;
  localparam logic [9:0] RESET_TOTAL_DEF   = 10'd960;
  localparam logic [7:0] SLOT_DEF          = 8'd60;
  localparam logic [7:0] SHORT_LOW_DEF     = 8'd1;
  localparam logic [7:0] READ_SMPL_DEF     = 8'd10;

  // one classified tick request
  typedef struct packed {
    logic       is_cmd;
    op_t        op;
    logic [7:0] wbyte;
    logic       level;
  } tick_req_t;

endpackage

/* src/one_wire_bus_master_top.sv */
// 1-Wire bus master: each request passes the front register, the queue and
// the result register; one tick request in and one result out per cycle
// while m_tready holds; a 4-entry queue lets input and output stall apart.
// Reset (rst, synchronous, active high) loads the default timing registers,
// idles the sequencer, clears presence and the read byte, empties the queue.
// Depends on owbm_pkg, owbm_front, owbm_queue, owbm_back.
module one_wire_bus_master_top (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // tick request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // write_byte[7:0], line_level[8], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // drive_low, busy_res, done_res, presence,
                                 // read_byte[11:4], rejected[12], zero pad
);
  import owbm_pkg::*;

  logic      push;
  logic      push_ready;
  tick_req_t push_req;
  logic      pop_valid;
  logic      pop;
  tick_req_t pop_req;

  // front: registers and classifies each tick request
  owbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push       (push),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  // short queue decoupling front from the engine
  owbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_req    (pop_req)
  );

  // engine: one bus tick per request, result held in an output register
  owbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_req   (pop_req),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* src/owbm_front.sv */
// Front stage: takes tick requests from the input stream and classifies them.
// Depends on owbm_pkg.
module owbm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [owbm_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]                   s_tuser,
  output logic                         push,
  input  logic                         push_ready,
  output owbm_pkg::tick_req_t          push_req
);
  import owbm_pkg::*;

  logic      valid;
  tick_req_t req;
  tick_req_t req_next;

  always_comb begin
    req_next.op     = op_t'(s_tuser);
    req_next.is_cmd = (req_next.op != OP_IDLE);
    req_next.wbyte  = s_tdata[7:0];
    req_next.level  = s_tdata[8];
  end

  assign push     = valid;
  assign push_req = req;
  assign s_tready = !valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req <= req_next;
    end
  end

endmodule

/* src/owbm_queue.sv */
// Short FIFO between the front stage and the bus engine.
// Depends on owbm_pkg.
module owbm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                push_ready,
  input  owbm_pkg::tick_req_t push_req,
  output logic                pop_valid,
  input  logic                pop,
  output owbm_pkg::tick_req_t pop_req
);
  import owbm_pkg::*;

  tick_req_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_req    = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count missed a pop");

endmodule

/* src/owbm_back.sv */
// Bus engine: runs reset, write and read sequences one tick per request,
// holds the timing registers and the registered result stage.
// Depends on owbm_pkg.
module owbm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owbm_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  logic                              pop_valid,
  output logic                              pop,
  input  owbm_pkg::tick_req_t               pop_req,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [owbm_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import owbm_pkg::*;

  // timing registers
  logic [9:0] reset_low_time;
  logic [9:0] presence_sample_time;
  logic [9:0] reset_total_time;
  logic [7:0] slot_time;
  logic [7:0] short_low_time;
  logic [7:0] read_sample_time;

  // sequence state
  op_t                    operation;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [2:0]             bit_index;
  logic [7:0]             shift_byte;
  logic                   presence_flag;
  logic [7:0]             read_result;

  op_t                    operation_next;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic [2:0]             bit_index_next;
  logic [7:0]             shift_byte_next;
  logic                   presence_flag_next;
  logic [7:0]             read_result_next;

  // result register
  logic out_drive;
  logic out_busy;
  logic out_done;
  logic out_rejected;
  logic drive_next;
  logic done_next;
  logic rejected_next;

  logic [CMP_WIDTH-1:0]   t_ext;
  logic [CMP_WIDTH-1:0]   t_inc;
  logic                   slot_end;
  logic                   cur_bit;

  assign pop = pop_valid && (!m_tvalid || m_tready);

  always_comb begin
    operation_next     = operation;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    read_result_next   = read_result;
    drive_next         = 1'b0;
    done_next          = 1'b0;
    rejected_next      = 1'b0;
    slot_end           = 1'b0;
    cur_bit            = 1'b0;

    // command start or rejection
    if (pop_req.is_cmd) begin
      if (operation != OP_IDLE) begin
        rejected_next = 1'b1;
      end else begin
        operation_next  = pop_req.op;
        tick_count_next = '0;
        bit_index_next  = '0;
        shift_byte_next = (pop_req.op == OP_WRITE) ? pop_req.wbyte : 8'd0;
        if (pop_req.op == OP_RESET) presence_flag_next = 1'b0;
      end
    end

    t_ext = CMP_WIDTH'(tick_count_next);
    t_inc = t_ext + 1'b1;

    unique case (operation_next)
      OP_RESET: begin
        drive_next = (t_ext < CMP_WIDTH'(reset_low_time));
        if (t_ext == CMP_WIDTH'(presence_sample_time)) begin
          presence_flag_next = !pop_req.level;
        end
        if (t_inc >= CMP_WIDTH'(reset_total_time)) begin
          done_next       = 1'b1;
          operation_next  = OP_IDLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = COUNT_WIDTH'(t_inc);
        end
      end
      OP_WRITE: begin
        cur_bit    = shift_byte_next[bit_index_next];
        drive_next = cur_bit ? (t_ext < CMP_WIDTH'(short_low_time)) : 1'b1;
        slot_end   = (t_inc >= CMP_WIDTH'(slot_time));
      end
      OP_READ: begin
        drive_next = (t_ext < CMP_WIDTH'(short_low_time));
        if (t_ext == CMP_WIDTH'(read_sample_time) && pop_req.level) begin
          shift_byte_next[bit_index_next] = 1'b1;
        end
        slot_end = (t_inc >= CMP_WIDTH'(slot_time));
      end
      default: ;
    endcase

    // common end-of-slot handling for write and read
    if (operation_next == OP_WRITE || operation_next == OP_READ) begin
      if (slot_end) begin
        tick_count_next = '0;
        if (bit_index_next == 3'd7) begin
          bit_index_next = '0;
          done_next      = 1'b1;
          if (operation_next == OP_READ) read_result_next = shift_byte_next;
          operation_next = OP_IDLE;
        end else begin
          bit_index_next = bit_index_next + 1'b1;
        end
      end else begin
        tick_count_next = COUNT_WIDTH'(t_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time       <= RESET_LOW_DEF;
      presence_sample_time <= PRESENCE_SMPL_DEF;
      reset_total_time     <= RESET_TOTAL_DEF;
      slot_time            <= SLOT_DEF;
      short_low_time       <= SHORT_LOW_DEF;
      read_sample_time     <= READ_SMPL_DEF;
      operation            <= OP_IDLE;
      tick_count           <= '0;
      bit_index            <= '0;
      shift_byte           <= '0;
      presence_flag        <= 1'b0;
      read_result          <= '0;
      m_tvalid             <= 1'b0;
      out_drive            <= 1'b0;
      out_busy             <= 1'b0;
      out_done             <= 1'b0;
      out_rejected         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_RESET_LOW:     reset_low_time       <= cfg_data[9:0];
          REG_PRESENCE_SMPL: presence_sample_time <= cfg_data[9:0];
          REG_RESET_TOTAL:   reset_total_time     <= cfg_data[9:0];
          REG_SLOT:          slot_time            <= cfg_data[7:0];
          REG_SHORT_LOW:     short_low_time       <= cfg_data[7:0];
          REG_READ_SMPL:     read_sample_time     <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (pop) begin
        operation     <= operation_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        presence_flag <= presence_flag_next;
        read_result   <= read_result_next;
        m_tvalid      <= 1'b1;
        out_drive     <= drive_next;
        out_busy      <= (operation_next != OP_IDLE);
        out_done      <= done_next;
        out_rejected  <= rejected_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // drive_low, busy, done, presence, read_byte, rejected from bit 0 up
  assign m_tdata = {3'b000, out_rejected, read_result, presence_flag,
                    out_done, out_busy, out_drive};

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_done) |-> !out_busy)
    else $error("done reported while still busy");

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_busy == (operation != OP_IDLE)))
    else $error("busy flag disagrees with sequence state");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (pop && operation == OP_IDLE) |=> !out_rejected)
    else $error("request rejected while idle");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (operation == OP_IDLE) |-> (tick_count == '0 && bit_index == '0))
    else $error("counters not cleared at idle");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the 1-Wire bus master: directed table, random runs, widest timing.
// Depends on owbm_pkg and one_wire_bus_master_top with its submodules.
module tb_top;
  import owbm_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off to fill the queue

  // indexes past the register file; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // result word, packed so that drive_low lands in bit 0 of m_tdata
  typedef struct packed {
    logic       rejected;
    logic [7:0] read_byte;
    logic       presence;
    logic       done;
    logic       busy;
    logic       drive_low;
  } bus_status_t;

  // one row of the directed table: either a register write or a request
  // followed by reps-1 plain ticks at the same line level
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [9:0]           val;
    op_t                  kind;
    logic [7:0]           wbyte;
    logic                 level;
    int                   reps;
    bit                   typed;
    bus_status_t          status;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // write_byte[7:0], line_level[8], zero pad
  logic [1:0]  s_tuser;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // drive_low, busy, done, presence, read_byte[11:4],
                          // rejected[12], zero pad

  // typed expectation travelling alongside the request being offered
  logic        item_typed;
  bus_status_t item_status;

  always #5 clk = ~clk;

  one_wire_bus_master_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Bus master predictor: timing registers and sequencer state
  // ---------------------------------------------------------------------------
  logic [9:0]             t_reset_low     = RESET_LOW_DEF;
  logic [9:0]             t_presence_smpl = PRESENCE_SMPL_DEF;
  logic [9:0]             t_reset_total   = RESET_TOTAL_DEF;
  logic [7:0]             t_slot          = SLOT_DEF;
  logic [7:0]             t_short_low     = SHORT_LOW_DEF;
  logic [7:0]             t_read_smpl     = READ_SMPL_DEF;

  op_t                    seq_op       = OP_IDLE;
  logic [COUNT_WIDTH-1:0] seq_ticks    = '0;
  logic [2:0]             seq_bit      = '0;
  logic [7:0]             seq_shift    = '0;
  logic                   seq_presence = 1'b0;
  logic [7:0]             seq_read     = '0;

  // register write as the block sees it; 8-bit registers keep the low byte
  function automatic void timing_write(logic [2:0] idx, logic [9:0] val);
    case (idx)
      REG_RESET_LOW:     t_reset_low     = val;
      REG_PRESENCE_SMPL: t_presence_smpl = val;
      REG_RESET_TOTAL:   t_reset_total   = val;
      REG_SLOT:          t_slot          = val[7:0];
      REG_SHORT_LOW:     t_short_low     = val[7:0];
      REG_READ_SMPL:     t_read_smpl     = val[7:0];
      default: ;
    endcase
  endfunction

  // advance the sequencer by one microsecond tick, return the status it reports
  function automatic bus_status_t next_bus_status(op_t kind, logic [7:0] wbyte, logic level);
    bus_status_t r;
    int t;
    r = '0;
    if (kind != OP_IDLE) begin
      if (seq_op != OP_IDLE) begin
        r.rejected = 1'b1;           // command while busy: dropped
      end else begin
        seq_op    = kind;
        seq_ticks = '0;
        seq_bit   = '0;
        seq_shift = (kind == OP_WRITE) ? wbyte : 8'h00;
        if (kind == OP_RESET) seq_presence = 1'b0;
      end
    end

    t = seq_ticks;
    case (seq_op)
      OP_RESET: begin
        r.drive_low = (t < t_reset_low);
        // sampled even while still pulling low
        if (t == t_presence_smpl) seq_presence = !level;
        if (t + 1 >= t_reset_total) begin   // a total of zero ends at once
          r.done    = 1'b1;
          seq_op    = OP_IDLE;
          seq_ticks = '0;
        end else begin
          seq_ticks = COUNT_WIDTH'(t + 1);
        end
      end
      OP_WRITE: r.drive_low = seq_shift[seq_bit] ? (t < t_short_low) : 1'b1;
      OP_READ: begin
        r.drive_low = (t < t_short_low);
        if (t == t_read_smpl && level) seq_shift[seq_bit] = 1'b1;
      end
      default: ;
    endcase

    // slot bookkeeping shared by write and read, LSB first
    if (seq_op == OP_WRITE || seq_op == OP_READ) begin
      if (t + 1 >= t_slot) begin
        seq_ticks = '0;
        if (seq_bit == 3'd7) begin
          seq_bit = '0;
          if (seq_op == OP_READ) seq_read = seq_shift;
          r.done = 1'b1;
          seq_op = OP_IDLE;
        end else begin
          seq_bit = seq_bit + 3'd1;
        end
      end else begin
        seq_ticks = COUNT_WIDTH'(t + 1);
      end
    end

    r.busy      = (seq_op != OP_IDLE);
    r.presence  = seq_presence;
    r.read_byte = seq_read;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted result
  // ---------------------------------------------------------------------------
  bus_status_t pending_status[$];
  bus_status_t mon_pred, mon_got, mon_want;
  int n_sent, n_results, n_done, n_rejected, n_reg_writes, n_err;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) begin
        timing_write(cfg_index, cfg_data);
        n_reg_writes++;
      end
      if (s_tvalid && s_tready) begin
        mon_pred = next_bus_status(op_t'(s_tuser), s_tdata[7:0], s_tdata[8]);
        pending_status.push_back(item_typed ? item_status : mon_pred);
        if (mon_pred.done) n_done++;
        if (mon_pred.rejected) n_rejected++;
      end
      if (m_tvalid && m_tready) begin
        mon_got = bus_status_t'(m_tdata[12:0]);
        n_results++;
        if (pending_status.size() == 0) begin
          if (n_err < 10) $display("ERROR: result %h with nothing expected", m_tdata);
          n_err++;
        end else begin
          mon_want = pending_status.pop_front();
          if (mon_got !== mon_want || m_tdata[15:13] !== 3'b000) begin
            if (n_err < 10)
              $display("ERROR: result %0d exp drv=%b busy=%b done=%b pres=%b rd=%h rej=%b",
                       n_results, mon_want.drive_low, mon_want.busy, mon_want.done,
                       mon_want.presence, mon_want.read_byte, mon_want.rejected,
                       "  got drv=%b busy=%b done=%b pres=%b rd=%h rej=%b pad=%b",
                       mon_got.drive_low, mon_got.busy, mon_got.done,
                       mon_got.presence, mon_got.read_byte, mon_got.rejected,
                       m_tdata[15:13]);
            n_err++;
          end
        end
      end
    end
  end

  // watchdog: any handshake or register write counts as progress
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off when asked
  // ---------------------------------------------------------------------------
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // offer one tick request and return right after the edge that takes it;
  // s_tready is sampled at the falling edge where everything has settled
  task automatic send_tick(op_t k, logic [7:0] b, logic lv,
                           bit typed = 1'b0, bus_status_t s = '0);
    bit ok;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= k;
    s_tdata     <= {7'b0, lv, b};
    item_typed  <= typed;
    item_status <= s;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    n_sent++;
  endtask

  // registers change only with the pipeline drained
  task automatic cfg_write(logic [2:0] idx, logic [9:0] val);
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_timing(logic [9:0] rl, logic [9:0] ps, logic [9:0] rt,
                            logic [9:0] sl, logic [9:0] sh, logic [9:0] rs);
    cfg_write(REG_RESET_LOW, rl);
    cfg_write(REG_PRESENCE_SMPL, ps);
    cfg_write(REG_RESET_TOTAL, rt);
    cfg_write(REG_SLOT, sl);
    cfg_write(REG_SHORT_LOW, sh);
    cfg_write(REG_READ_SMPL, rs);
  endtask

  // one command followed by enough ticks to finish it; with noise some ticks
  // carry stray commands (rejected) and a few sequences are cut short
  task automatic run_sequence(op_t k, logic [7:0] b, int noise_pct);
    int len;
    if (k == OP_RESET) len = (t_reset_total == 0) ? 1 : t_reset_total;
    else               len = 8 * ((t_slot == 0) ? 1 : t_slot);
    if (noise_pct > 0 && $urandom_range(0, 9) == 0) len = $urandom_range(1, len);
    send_tick(k, b, 1'($urandom_range(0, 1)));
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_tick(op_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
      else
        send_tick(OP_IDLE, 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // random timing (small, so bytes and resets stay short), then sequences;
  // with hold set the receiver backs off once while requests keep coming
  task automatic run_random(int n, int snd, int rcv, bit hold = 1'b0);
    int stop;
    logic [9:0] sl;
    stop = n_sent + n;
    sl = 10'($urandom_range(0, 12));
    set_timing(10'($urandom_range(0, 24)), 10'($urandom_range(0, 30)),
               10'($urandom_range(0, 30)), sl,
               10'($urandom_range(0, sl + 1)), 10'($urandom_range(0, sl + 1)));
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    if (hold) hold_go = 1'b1;
    while (n_sent < stop) begin
      run_sequence(op_t'($urandom_range(1, 3)), 8'($urandom), 5);
      repeat ($urandom_range(0, 3))
        send_tick(OP_IDLE, 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic bus_status_t status_of(logic drv, logic busy, logic done, logic pres,
                                            logic [7:0] rd, logic rej);
    return '{rejected: rej, read_byte: rd, presence: pres, done: done,
             busy: busy, drive_low: drv};
  endfunction

  function automatic step_row_t reg_row(logic [2:0] idx, logic [9:0] val);
    step_row_t r;
    r = '{is_reg: 1'b1, idx: idx, val: val, kind: OP_IDLE, wbyte: 8'h00, level: 1'b0,
          reps: 0, typed: 1'b0, status: '0};
    return r;
  endfunction

  function automatic step_row_t cmd_row(op_t k, logic [7:0] b, logic lv, int reps,
                                        bit typed = 1'b0, bus_status_t s = '0);
    step_row_t r;
    r = '{is_reg: 1'b0, idx: '0, val: '0, kind: k, wbyte: b, level: lv,
          reps: reps, typed: typed, status: s};
    return r;
  endfunction

  step_row_t dir_rows[$];

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= OP_IDLE;
    item_typed  <= 1'b0;
    item_status <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Short timing so each byte is 8 ticks: reset low 2, presence at 3,
    // total 6, one-tick slots, one low tick, read sampled at tick 0.
    dir_rows = '{
      // out of reset: nothing driven, nothing busy
      cmd_row(OP_IDLE,  8'h00, 1'b1, 1, 1'b1,
              status_of(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0)),
      reg_row(REG_RESET_LOW,     10'd2),
      reg_row(REG_PRESENCE_SMPL, 10'd3),
      reg_row(REG_RESET_TOTAL,   10'd6),
      reg_row(REG_SLOT,          10'd1),
      reg_row(REG_SHORT_LOW,     10'd1),
      reg_row(REG_READ_SMPL,     10'd0),
      // reset pulse starts low and busy
      cmd_row(OP_RESET, 8'h00, 1'b1, 1, 1'b1,
              status_of(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0)),
      // a write during the reset is refused
      cmd_row(OP_WRITE, 8'h55, 1'b1, 1, 1'b1,
              status_of(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1)),
      // device pulls low at the sample tick: presence seen
      cmd_row(OP_IDLE,  8'h00, 1'b0, 4),
      cmd_row(OP_WRITE, 8'hA5, 1'b1, 8),
      cmd_row(OP_READ,  8'h00, 1'b1, 8),
      // zero slot acts as one tick, no low tick, sample point beyond the slot
      reg_row(REG_SLOT,          10'd0),
      reg_row(REG_SHORT_LOW,     10'd0),
      reg_row(REG_READ_SMPL,     10'd1),
      cmd_row(OP_READ,  8'h00, 1'b1, 8),
      // zero-length reset, sampled on tick 0 while still driven low
      reg_row(REG_RESET_TOTAL,   10'd0),
      reg_row(REG_PRESENCE_SMPL, 10'd0),
      cmd_row(OP_RESET, 8'h00, 1'b0, 1),
      // sample point after the end: presence cleared and stays clear
      reg_row(REG_PRESENCE_SMPL, 10'd1023),
      cmd_row(OP_RESET, 8'h00, 1'b0, 1),
      reg_row(REG_UNUSED_LO,     10'h3FF),
      reg_row(REG_UNUSED_HI,     10'h2AA),
      cmd_row(OP_IDLE,  8'hFF, 1'b1, 1)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        cfg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_tick(dir_rows[i].kind, dir_rows[i].wbyte, dir_rows[i].level,
                  dir_rows[i].typed, dir_rows[i].status);
        for (int r = 1; r < dir_rows[i].reps; r++)
          send_tick(OP_IDLE, dir_rows[i].wbyte, dir_rows[i].level);
      end
    end

    // Random phases, two timing sets each. The first phase has no idling and
    // one long receiver hold-off so the queue fills and input backs up.
    run_random(100, 0, 0, 1'b1);
    run_random(100, 0, 0);
    run_random(100, 59, 0);
    run_random(100, 59, 0);
    run_random(100, 0, 59);
    run_random(100, 0, 59);
    run_random(100, 17, 17);
    run_random(100, 17, 17);

    // Widest timing: longest reset with the sample on its last tick, then one
    // 255-tick read slot sampled on its last tick. 0x3FF in an 8-bit register
    // keeps 255.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_timing(10'd1023, 10'd1022, 10'd1023, 10'h3FF, 10'd255, 10'd254);
    run_sequence(OP_RESET, 8'h00, 0);
    send_tick(OP_READ, 8'h00, 1'b1);
    repeat (254) send_tick(OP_IDLE, 8'h00, 1'b1);

    // drain, then let anything stray arrive
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d tick requests and %0d results: %0d commands finished,",
             n_sent, n_results, n_done);
    $display("%0d rejected, %0d register writes, %0d mismatches", n_rejected,
             n_reg_writes, n_err);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
